>>> src/i2cm_pkg.sv
// Shared types and constants of the I2C master bit engine.
`timescale 1ns / 1ps
package i2cm_pkg;

  // Decoded command classes, produced by the front end.
  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_WACK  = 3'd4;
  localparam logic [2:0] CMD_NONE  = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_HOLD   = 2'd0;
  localparam logic [1:0] REG_BIT    = 2'd1;
  localparam logic [1:0] REG_SAMPLE = 2'd2;
  localparam logic [1:0] REG_POLLS  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [9:0] HOLD_RESET   = 10'd34;
  localparam logic [9:0] BIT_RESET    = 10'd17;
  localparam logic [9:0] SAMPLE_RESET = 10'd9;
  localparam logic [7:0] POLLS_RESET  = 8'd250;

  // One classified tick as it waits in the queue.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // One result.
  typedef struct packed {
    logic       ack_failed;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_out;
    logic       scl_out;
  } res_t;

  // Configuration as seen by the back end.
  typedef struct packed {
    logic [9:0] hold;
    logic [9:0] bitph;
    logic [9:0] sample;
    logic [7:0] polls;
  } cfg_t;

endpackage

>>> src/i2cm_front.sv
// Front end: accepts ticks, decodes the command and queues them.
`timescale 1ns / 1ps
module i2cm_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,
  input  logic             in_tuser,
  output logic             q_valid,
  input  logic             q_pop,
  output i2cm_pkg::tick_t  q_tick
);

  i2cm_pkg::tick_t slot_r [2];
  logic            rd_r, rd_nxt, wr_r, wr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push, pop;
  i2cm_pkg::tick_t dec;

  // Classify the request: unknown opcodes and ticks without command become idle ticks.
  always_comb begin
    dec.tx_byte  = in_tdata[10:3];
    dec.send_ack = in_tdata[11];
    dec.sda_in   = in_tdata[12];
    dec.cmd      = i2cm_pkg::CMD_NONE;
    if (in_tuser) begin
      case (in_tdata[2:0])
        i2cm_pkg::CMD_START: dec.cmd = i2cm_pkg::CMD_START;
        i2cm_pkg::CMD_STOP:  dec.cmd = i2cm_pkg::CMD_STOP;
        i2cm_pkg::CMD_WRITE: dec.cmd = i2cm_pkg::CMD_WRITE;
        i2cm_pkg::CMD_READ:  dec.cmd = i2cm_pkg::CMD_READ;
        i2cm_pkg::CMD_WACK:  dec.cmd = i2cm_pkg::CMD_WACK;
        default:             dec.cmd = i2cm_pkg::CMD_NONE;
      endcase
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_tick    = slot_r[rd_r];

  // Queue pointers and fill count.
  always_comb begin
    rd_nxt  = pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= dec;
    end
  end

endmodule

>>> src/i2cm_back.sv
// Back end: the bus phase sequencer and the result register.
`timescale 1ns / 1ps
module i2cm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  i2cm_pkg::cfg_t   cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  i2cm_pkg::tick_t  q_tick,
  output logic             out_tvalid,
  input  logic             out_tready,
  output i2cm_pkg::res_t   out_res
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST1     = 4'd1;
  localparam logic [3:0] PH_ST2     = 4'd2;
  localparam logic [3:0] PH_SP1     = 4'd3;
  localparam logic [3:0] PH_SP2     = 4'd4;
  localparam logic [3:0] PH_WA1     = 4'd5;
  localparam logic [3:0] PH_WA2     = 4'd6;
  localparam logic [3:0] PH_POLL    = 4'd7;
  localparam logic [3:0] PH_WB_LOW  = 4'd8;
  localparam logic [3:0] PH_WB_HIGH = 4'd9;
  localparam logic [3:0] PH_WB_TAIL = 4'd10;
  localparam logic [3:0] PH_RB_LOW  = 4'd11;
  localparam logic [3:0] PH_RB_HIGH = 4'd12;
  localparam logic [3:0] PH_AK_LOW  = 4'd13;
  localparam logic [3:0] PH_AK_HIGH = 4'd14;

  logic [3:0] phase_r, phase_nxt;
  logic [9:0] tick_r, tick_nxt;
  logic [3:0] bit_r, bit_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [7:0] poll_r, poll_nxt;
  logic       ackc_r, ackc_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       dir_r, dir_nxt;
  logic       fail_r, fail_nxt;
  logic       done;
  logic [9:0] len_raw, len;
  logic [9:0] tick_inc;
  logic [3:0] bit_inc;
  logic       ovalid_r;
  i2cm_pkg::res_t res_r;

  // The result slot frees when empty or when its request is taken.
  assign q_pop      = !ovalid_r || out_tready;
  assign out_tvalid = ovalid_r;
  assign out_res    = res_r;

  // Length of the current phase; zero counts as one.
  always_comb begin
    case (phase_r)
      PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_WA1, PH_WA2: len_raw = cfg.hold;
      PH_RB_HIGH: len_raw = cfg.sample;
      default:    len_raw = cfg.bitph;
    endcase
    len = (len_raw == 10'd0) ? 10'd1 : len_raw;
  end

  assign tick_inc = tick_r + 10'd1;
  assign bit_inc  = bit_r + 4'd1;

  // One tick of the phase sequencer.
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    poll_nxt  = poll_r;
    ackc_nxt  = ackc_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    dir_nxt   = dir_r;
    fail_nxt  = fail_r;
    done      = 1'b0;
    if (phase_r == PH_IDLE) begin
      tick_nxt = 10'd0;
      case (q_tick.cmd)
        i2cm_pkg::CMD_START: begin
          dir_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; phase_nxt = PH_ST1;
        end
        i2cm_pkg::CMD_STOP: begin
          dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0; phase_nxt = PH_SP1;
        end
        i2cm_pkg::CMD_WRITE: begin
          dir_nxt = 1'b1; scl_nxt = 1'b0; bit_nxt = 4'd0;
          sda_nxt = q_tick.tx_byte[7];
          tx_nxt  = {q_tick.tx_byte[6:0], 1'b0};
          phase_nxt = PH_WB_LOW;
        end
        i2cm_pkg::CMD_READ: begin
          dir_nxt = 1'b0; scl_nxt = 1'b0; rx_nxt = 8'd0; bit_nxt = 4'd0;
          ackc_nxt = q_tick.send_ack; phase_nxt = PH_RB_LOW;
        end
        i2cm_pkg::CMD_WACK: begin
          dir_nxt = 1'b0; sda_nxt = 1'b1; fail_nxt = 1'b0; phase_nxt = PH_WA1;
        end
        default: tick_nxt = tick_r;
      endcase
    end else if (phase_r == PH_POLL) begin
      if (!q_tick.sda_in) begin
        scl_nxt = 1'b0;
        done    = 1'b1;
      end else if (poll_r >= cfg.polls) begin
        fail_nxt = 1'b1; dir_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0;
        phase_nxt = PH_SP1; tick_nxt = 10'd0;
      end else begin
        poll_nxt = poll_r + 8'd1;
      end
    end else begin
      tick_nxt = tick_inc;
      if (tick_inc >= len) begin
        tick_nxt = 10'd0;
        case (phase_r)
          PH_ST1: begin sda_nxt = 1'b0; phase_nxt = PH_ST2; end
          PH_ST2: begin scl_nxt = 1'b0; done = 1'b1; end
          PH_SP1: begin scl_nxt = 1'b1; sda_nxt = 1'b1; phase_nxt = PH_SP2; end
          PH_SP2: done = 1'b1;
          PH_WA1: begin scl_nxt = 1'b1; phase_nxt = PH_WA2; end
          PH_WA2: begin poll_nxt = 8'd0; phase_nxt = PH_POLL; end
          PH_WB_LOW: begin scl_nxt = 1'b1; phase_nxt = PH_WB_HIGH; end
          PH_WB_HIGH: begin scl_nxt = 1'b0; phase_nxt = PH_WB_TAIL; end
          PH_WB_TAIL: begin
            bit_nxt = bit_inc;
            if (bit_inc >= 4'd8) begin
              done = 1'b1;
            end else begin
              sda_nxt = tx_r[7];
              tx_nxt  = {tx_r[6:0], 1'b0};
              phase_nxt = PH_WB_LOW;
            end
          end
          PH_RB_LOW: begin
            scl_nxt = 1'b1;
            rx_nxt  = {rx_r[6:0], q_tick.sda_in};
            phase_nxt = PH_RB_HIGH;
          end
          PH_RB_HIGH: begin
            bit_nxt = bit_inc;
            scl_nxt = 1'b0;
            if (bit_inc >= 4'd8) begin
              dir_nxt = 1'b1;
              sda_nxt = !ackc_r;
              phase_nxt = PH_AK_LOW;
            end else begin
              phase_nxt = PH_RB_LOW;
            end
          end
          PH_AK_LOW: begin scl_nxt = 1'b1; phase_nxt = PH_AK_HIGH; end
          PH_AK_HIGH: begin scl_nxt = 1'b0; done = 1'b1; end
          default: done = 1'b1;
        endcase
      end
    end
    if (done) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = 10'd0;
    end
  end

  // Sequencer state, advanced once per tick taken from the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= 10'd0;
      bit_r   <= 4'd0;
      tx_r    <= 8'd0;
      rx_r    <= 8'd0;
      poll_r  <= 8'd0;
      ackc_r  <= 1'b0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      dir_r   <= 1'b1;
      fail_r  <= 1'b0;
    end else if (q_valid && q_pop) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      poll_r  <= poll_nxt;
      ackc_r  <= ackc_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      dir_r   <= dir_nxt;
      fail_r  <= fail_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (q_pop) begin
      ovalid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_pop) begin
      res_r.scl_out    <= scl_nxt;
      res_r.sda_out    <= sda_nxt;
      res_r.sda_drive  <= dir_nxt;
      res_r.busy_res   <= (phase_nxt != PH_IDLE);
      res_r.done_res   <= done;
      res_r.rx_byte    <= rx_nxt;
      res_r.ack_failed <= fail_nxt;
    end
  end

endmodule

>>> src/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: configuration registers, front and back ends.
`timescale 1ns / 1ps
// Each input request is one timing tick and yields exactly one result request
// with the line levels after that tick. The engine takes one tick per clock cycle
// while the result slot is free or its result is taken; a tick passes a two-entry
// tick queue, then the result register. The back end's single phase sequencer
// sets that rate. Commands given while a command runs are ignored. The user must
// write configuration only while idle; the block itself does not enforce this.
module i2c_master_bit_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero[15:13]
  input  logic [15:0] in_tdata,
  // cmd_valid[0]
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
  // rx_byte[12:5], ack_failed[13], zero[15:14]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);

  i2cm_pkg::cfg_t  cfg_r;
  i2cm_pkg::tick_t q_tick;
  i2cm_pkg::res_t  res;
  logic            q_valid, q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold   <= i2cm_pkg::HOLD_RESET;
      cfg_r.bitph  <= i2cm_pkg::BIT_RESET;
      cfg_r.sample <= i2cm_pkg::SAMPLE_RESET;
      cfg_r.polls  <= i2cm_pkg::POLLS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::REG_HOLD:   cfg_r.hold   <= cfg_wdata;
        i2cm_pkg::REG_BIT:    cfg_r.bitph  <= cfg_wdata;
        i2cm_pkg::REG_SAMPLE: cfg_r.sample <= cfg_wdata;
        i2cm_pkg::REG_POLLS:  cfg_r.polls  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_tick    (q_tick)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_tick     (q_tick),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {2'b00, res.ack_failed, res.rx_byte, res.done_res, res.busy_res,
                      res.sda_drive, res.sda_out, res.scl_out};

  // A completing tick never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done and busy in the same result");

  // Nothing is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // The queue always has room for an input when no result is waiting.
  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("queue full with empty result slot");

endmodule
